### rtl/core/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEVER(label, cond, msg)
`endif
`endif

### rtl/core/ppal_pkg.sv
`default_nettype none
package ppal_pkg;
  localparam int CW = 20;
  localparam int LW = 32;

  typedef struct packed {
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] point_z;
    logic [LW-1:0]        target_length;
    logic                 last_point;
  } in_item_t;

  typedef struct packed {
    logic signed [CW-1:0] result_x;
    logic signed [CW-1:0] result_y;
    logic signed [CW-1:0] result_z;
    logic                 reached_end;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the input beat and start the segment length
    logic sqrt_step; // one square root iteration
    logic seg_done;  // decide on this segment and update the running length
    logic div_start; // load the divider for axis div_axis
    logic div_step;  // one restoring division step
    logic div_end;   // write the quotient of the current axis
    logic [1:0] div_axis;
    logic finish;    // move the current point to the previous one and close the beat
  } ppal_cmd_t;

  typedef struct packed {
    logic first;     // the captured point opens a path
    logic hit;       // this segment needs the interpolation
    logic sqrt_last;
    logic div_last;
  } ppal_sts_t;
endpackage
`default_nettype wire

### rtl/core/polyline_point_at_length.sv
// Each point runs through the bit-serial square root and, when its segment interpolates,
// through the shared restoring divider once per axis; the point that closes a path then
// offers its result.
// One point is in work at a time; a point that closes no path frees the input once it has
// passed S_FIN, and a result holds the input until it is taken.
// Reset (rst_n, synchronous) clears the path state; the next point opens a path.
`default_nettype none
module polyline_point_at_length (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  ppal_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output ppal_pkg::out_item_t  out_data
);
  import ppal_pkg::*;

  ppal_cmd_t cmd;
  ppal_sts_t sts;

  ppal_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_last(in_data.last_point),
    .out_valid, .out_ready, .sts, .cmd
  );

  ppal_datapath u_dp (
    .clk, .rst_n, .in_data, .cmd, .sts, .out_data
  );
endmodule
`default_nettype wire

### rtl/core/ppal_datapath.sv
`default_nettype none
`include "assert_macros.svh"
module ppal_datapath (
  input  wire                  clk,
  input  wire                  rst_n,
  input  ppal_pkg::in_item_t   in_data,
  input  ppal_pkg::ppal_cmd_t  cmd,
  output ppal_pkg::ppal_sts_t  sts,
  output ppal_pkg::out_item_t  out_data
);
  import ppal_pkg::*;

  localparam int COORD_WIDTH  = CW;
  localparam int LENGTH_WIDTH = LW;
  localparam int DW  = COORD_WIDTH + 1;      // coordinate difference
  localparam int SQW = 2 * DW + 2;           // sum of three squares
  localparam int RTW = SQW / 2;              // root width
  localparam int SQI = RTW;                  // square root iterations
  localparam int NW  = LENGTH_WIDTH + DW;    // |d| * num
  localparam int SCW = $clog2(NW + 1);
  localparam int RCW = $clog2(SQI + 1);
  localparam logic [LENGTH_WIDTH-1:0] LMAX = '1;

  logic signed [COORD_WIDTH-1:0] prev_r [3];
  logic signed [COORD_WIDTH-1:0] cur_r  [3];
  logic signed [COORD_WIDTH-1:0] found_r[3];
  logic [LENGTH_WIDTH-1:0] run_r, tgt_r, num_r;
  logic found_r_flag, first_r, last_r;
  logic [DW-1:0] dabs_r[3];
  logic dneg_r[3];
  logic [SQW-1:0] rad_r;
  logic [RTW-1:0] root_r;
  logic [SQW+1:0] rem_r;
  logic [RCW-1:0] scnt_r;
  logic [NW-1:0] dvd_r;
  logic [RTW:0]  drem_r;
  logic [SCW-1:0] dcnt_r;
  logic hit_r;

  logic signed [DW-1:0] dlt[3];
  logic [DW-1:0] dab[3];
  logic [2*DW-1:0] sq[3];
  logic [SQW+1:0] trial;
  logic [RTW:0] dtrial;
  logic [LENGTH_WIDTH:0] sum;
  logic [RTW-1:0] half;

  function automatic logic signed [COORD_WIDTH-1:0] in_data_c(input int i);
    case (i)
      0:       return in_data.point_x;
      1:       return in_data.point_y;
      default: return in_data.point_z;
    endcase
  endfunction

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dlt[i] = DW'(in_data_c(i)) - DW'(prev_r[i]);
      dab[i] = dlt[i][DW-1] ? DW'(-dlt[i]) : DW'(dlt[i]);
      sq[i]  = dab[i] * dab[i];
    end
    trial  = {rem_r[SQW-1:0], rad_r[SQW-1 -: 2]} - {root_r, 2'b01};
    dtrial = {drem_r[RTW-1:0], dvd_r[NW-1]} - {1'b0, root_r};
    sum    = {1'b0, run_r} + {{(LENGTH_WIDTH+1-RTW){1'b0}}, root_r};
    half   = root_r >> 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        prev_r[i] <= '0;
        found_r[i] <= '0;
      end
      run_r <= '0; tgt_r <= '0; found_r_flag <= 1'b0; first_r <= 1'b1;
      last_r <= 1'b0; scnt_r <= '0; dcnt_r <= '0; hit_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        for (int i = 0; i < 3; i++) begin
          cur_r[i]  <= in_data_c(i);
          dabs_r[i] <= dab[i];
          dneg_r[i] <= dlt[i][DW-1];
        end
        rad_r  <= SQW'(sq[0]) + SQW'(sq[1]) + SQW'(sq[2]);
        rem_r  <= '0;
        root_r <= '0;
        scnt_r <= '0;
        last_r <= in_data.last_point;
        if (first_r) begin
          tgt_r <= in_data.target_length;
          run_r <= '0;
          found_r_flag <= (in_data.target_length == '0);
          if (in_data.target_length == '0) begin
            for (int i = 0; i < 3; i++) found_r[i] <= in_data_c(i);
          end
        end
      end
      if (cmd.sqrt_step) begin
        rad_r  <= rad_r << 2;
        scnt_r <= scnt_r + 1'b1;
        if (!trial[SQW+1]) begin
          rem_r  <= trial;
          root_r <= {root_r[RTW-2:0], 1'b1};
        end else begin
          rem_r  <= {rem_r[SQW-1:0], rad_r[SQW-1 -: 2]};
          root_r <= {root_r[RTW-2:0], 1'b0};
        end
      end
      if (cmd.seg_done) begin
        hit_r <= !found_r_flag && (sum >= {1'b0, tgt_r});
        num_r <= tgt_r - run_r;
        if (!found_r_flag && (sum >= {1'b0, tgt_r})) found_r_flag <= 1'b1;
        run_r <= sum[LENGTH_WIDTH] ? LMAX : sum[LENGTH_WIDTH-1:0];
      end
      if (cmd.div_start) begin
        // Rounding bias of half the divisor goes in through the dividend.
        dvd_r  <= NW'(dabs_r[cmd.div_axis]) * NW'(num_r) + NW'(half);
        drem_r <= '0;
        dcnt_r <= '0;
      end
      if (cmd.div_step) begin
        dcnt_r <= dcnt_r + 1'b1;
        if (!dtrial[RTW]) begin
          drem_r <= dtrial;
          dvd_r  <= {dvd_r[NW-2:0], 1'b1};
        end else begin
          drem_r <= {drem_r[RTW-1:0], dvd_r[NW-1]};
          dvd_r  <= {dvd_r[NW-2:0], 1'b0};
        end
      end
      if (cmd.div_end) begin
        found_r[cmd.div_axis] <= (root_r == '0) ? prev_r[cmd.div_axis] :
          dneg_r[cmd.div_axis] ?
            COORD_WIDTH'(prev_r[cmd.div_axis] - COORD_WIDTH'(dvd_r)) :
            COORD_WIDTH'(prev_r[cmd.div_axis] + COORD_WIDTH'(dvd_r));
      end
      if (cmd.finish) begin
        for (int i = 0; i < 3; i++) prev_r[i] <= cur_r[i];
        first_r <= last_r;
        if (last_r) found_r_flag <= 1'b0;
      end
    end
  end

  logic reached;
  assign reached = tgt_r >= run_r;
  assign sts.first     = first_r;
  assign sts.hit       = hit_r;
  assign sts.sqrt_last = (scnt_r == RCW'(SQI - 1));
  assign sts.div_last  = (dcnt_r == SCW'(NW - 1));

  always_comb begin
    logic use_found;
    use_found = (tgt_r == '0) || (!reached && found_r_flag);
    out_data.result_x = use_found ? found_r[0] : cur_r[0];
    out_data.result_y = use_found ? found_r[1] : cur_r[1];
    out_data.result_z = use_found ? found_r[2] : cur_r[2];
    out_data.reached_end = reached;
  end

  `ASSERT_NEVER(a_cmd_overlap, cmd.load && cmd.finish, "load and finish together")
  `ASSERT_CLK(a_run_sat, cmd.seg_done |=> (run_r >= $past(run_r)), "running length shrank")
  `ASSERT_NEVER(a_step_mix, cmd.sqrt_step && cmd.div_step, "sqrt and div steps together")
endmodule
`default_nettype wire

### rtl/core/ppal_ctrl.sv
`default_nettype none
`include "assert_macros.svh"
module ppal_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire                  in_last,
  output logic                 out_valid,
  input  wire                  out_ready,
  input  ppal_pkg::ppal_sts_t  sts,
  output ppal_pkg::ppal_cmd_t  cmd
);
  import ppal_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SQRT  = 8'b0000_0010,
    S_SEG   = 8'b0000_0100,
    S_DLOAD = 8'b0000_1000,
    S_DIV   = 8'b0001_0000,
    S_DEND  = 8'b0010_0000,
    S_FIN   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0] axis_r, axis_nxt;
  logic last_r;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    cmd       = '0;
    cmd.div_axis = axis_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (sts.sqrt_last) state_nxt = sts.first ? S_FIN : S_SEG;
      end
      S_SEG: begin
        cmd.seg_done = 1'b1;
        state_nxt = S_DLOAD;
        axis_nxt  = 2'd0;
      end
      S_DLOAD: begin
        if (sts.hit) begin
          cmd.div_start = 1'b1;
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_DEND;
      end
      S_DEND: begin
        cmd.div_end = 1'b1;
        if (axis_r == 2'd2) begin
          state_nxt = S_FIN;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = S_DLOAD;
        end
      end
      S_FIN: begin
        state_nxt = last_r ? S_OUT : S_IDLE;
        if (!last_r) cmd.finish = 1'b1;
      end
      S_OUT: begin
        if (out_ready) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      axis_r  <= 2'd0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      if (cmd.load) last_r <= in_last;
    end
  end

  `ASSERT_NEVER(a_rdy_out, in_ready && out_valid, "ready while result pending")
  `ASSERT_CLK(a_onehot, $onehot(state_r), "state not one-hot")
  `ASSERT_CLK(a_axis, (axis_r != 2'd3), "axis out of range")
endmodule
`default_nettype wire

### bench/tb_polyline_point_at_length.sv
`timescale 1ns / 100ps
module tb_polyline_point_at_length;
  import ppal_pkg::*;

  localparam longint unsigned LEN_MAX = 64'hFFFF_FFFF;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int HOLDOFF_CYCLES = 2000;

  class point_scoreboard;
    longint prev_pt[3];
    longint found_pt[3];
    longint unsigned run_len;
    longint unsigned goal_len;
    bit found;
    bit opens_path = 1'b1;
    out_item_t expected_q[$];
    int errors;
    int results_seen;

    function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    function void note_point(in_item_t it);
      longint p[3];
      longint d[3];
      longint unsigned mag, sq, seg, sum, num, q;
      bit at_end;
      out_item_t r;
      longint v;
      p[0] = it.point_x;
      p[1] = it.point_y;
      p[2] = it.point_z;
      if (opens_path) begin
        goal_len = it.target_length;
        run_len = 0;
        found = 1'b0;
        if (goal_len == 0) begin
          found_pt = p;
          found = 1'b1;
        end
      end else begin
        sq = 0;
        for (int i = 0; i < 3; i++) begin
          d[i] = p[i] - prev_pt[i];
          mag = (d[i] < 0) ? -d[i] : d[i];
          sq += mag * mag;
        end
        seg = int_sqrt(sq);
        sum = run_len + seg;
        if (!found && sum >= goal_len) begin
          num = goal_len - run_len;
          for (int i = 0; i < 3; i++) begin
            mag = (d[i] < 0) ? -d[i] : d[i];
            q = (seg != 0) ? (mag * num + (seg >> 1)) / seg : 0;
            found_pt[i] = (d[i] < 0) ? prev_pt[i] - longint'(q) : prev_pt[i] + longint'(q);
          end
          found = 1'b1;
        end
        run_len = (sum > LEN_MAX) ? LEN_MAX : sum;
      end
      prev_pt = p;
      if (!it.last_point) begin
        opens_path = 1'b0;
        return;
      end
      at_end = goal_len >= run_len;
      for (int i = 0; i < 3; i++) begin
        if (goal_len == 0) v = found_pt[i];
        else if (at_end || !found) v = p[i];
        else v = found_pt[i];
        case (i)
          0: r.result_x = v[CW-1:0];
          1: r.result_y = v[CW-1:0];
          default: r.result_z = v[CW-1:0];
        endcase
      end
      r.reached_end = at_end;
      expected_q.push_back(r);
      opens_path = 1'b1;
      run_len = 0;
      found = 1'b0;
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      results_seen++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, got);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.result_x !== exp_r.result_x) begin
        $display("%0t: result_x expected %0d got %0d", $time, exp_r.result_x, got.result_x);
        errors++;
      end
      if (got.result_y !== exp_r.result_y) begin
        $display("%0t: result_y expected %0d got %0d", $time, exp_r.result_y, got.result_y);
        errors++;
      end
      if (got.result_z !== exp_r.result_z) begin
        $display("%0t: result_z expected %0d got %0d", $time, exp_r.result_z, got.result_z);
        errors++;
      end
      if (got.reached_end !== exp_r.reached_end) begin
        $display("%0t: reached_end expected %0b got %0b", $time, exp_r.reached_end,
                 got.reached_end);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  int cycles;
  point_scoreboard sb;

  polyline_point_at_length dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  task automatic send_point(input int x, input int y, input int z,
                            input logic [LW-1:0] goal, input int last, input int gap);
    in_item_t it;
    it.point_x = CW'(x);
    it.point_y = CW'(y);
    it.point_z = CW'(z);
    it.target_length = goal;
    it.last_point = (last != 0);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_point(it);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Receiver: mostly ready, short and occasional long stalls, and one long hold-off
  // so that the block backs up and stops taking points.
  initial begin
    int stall;
    bit held;
    stall = 0;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held && sb.results_seen >= 20) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(negedge clk);
      end else if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  initial begin
    logic signed [CW-1:0] px, py, pz;
    logic signed [CW-1:0] mx, my, mz;
    logic [LW-1:0] goal;
    int npts, span, mode, sent;
    logic signed [CW-1:0] lo, hi;
    lo = {1'b1, {(CW-1){1'b0}}};
    hi = {1'b0, {(CW-1){1'b1}}};
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Single point paths: zero target, and a target beyond the (zero) total.
    send_point(100, -200, 300, 0, 1, 0);
    send_point(hi, lo, hi, 32'd5, 1, 0);
    send_point(lo, lo, lo, 32'hFFFF_FFFF, 1, 1);
    // Corner to corner with zero, mid and huge targets.
    send_point(lo, lo, lo, 0, 0, 0);
    send_point(hi, hi, hi, 0, 1, 0);
    send_point(lo, hi, lo, 32'd900000, 0, 0);
    send_point(hi, lo, hi, 32'd900000, 1, 2);
    send_point(lo, lo, lo, 32'hFFFF_FFFF, 0, 0);
    send_point(hi, hi, hi, 0, 1, 0);
    // Zero-length segments around an interpolating one; target exactly the total.
    send_point(10, 10, 10, 32'd300, 0, 0);
    send_point(10, 10, 10, 0, 0, 0);
    send_point(310, 10, 10, 0, 0, 0);
    send_point(310, 10, 10, 0, 1, 0);
    send_point(0, 0, 0, 32'd300, 0, 0);
    send_point(0, -300, 0, 0, 1, 0);
    // Rounding: odd segment length, target inside the first segment.
    send_point(0, 0, 0, 32'd1, 0, 0);
    send_point(-3, 0, 0, 0, 0, 0);
    send_point(-3, 0, 7, 0, 1, 0);
    // Long corner-to-corner path whose total stays below a huge target.
    for (int i = 0; i < 200; i++)
      send_point((i % 2) ? hi : lo, (i % 2) ? hi : lo, (i % 2) ? lo : hi,
                 32'hFFFF_FFFF, i == 199, 0);

    sent = 0;
    while (sent < 530) begin
      npts = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 6);
      mode = $urandom_range(0, 9);
      span = (mode < 2) ? (1 << 19) : (1 << $urandom_range(2, 14));
      px = CW'($urandom);
      py = CW'($urandom);
      pz = CW'($urandom);
      case ($urandom_range(0, 9))
        0: goal = 0;
        1: goal = $urandom;
        2: goal = 32'hFFFF_FFFF;
        default: goal = $urandom_range(1, npts * span * 2);
      endcase
      for (int i = 0; i < npts; i++) begin
        // Only the first point's target counts; the later points carry random targets.
        send_point(px, py, pz, (i == 0) ? goal : $urandom, i == npts - 1, pick_gap());
        sent++;
        if (mode < 2) begin
          px = CW'($urandom);
          py = CW'($urandom);
          pz = CW'($urandom);
        end else begin
          mx = CW'($urandom_range(0, 2 * span) - span);
          my = CW'($urandom_range(0, 2 * span) - span);
          mz = ($urandom_range(0, 3) == 0) ? '0 : CW'($urandom_range(0, 2 * span) - span);
          px = px + mx;
          py = py + my;
          pz = pz + mz;
        end
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
